[rtl/pns_pkg.sv]
// Shared types and constants of the 3D gradient noise sampler.
// No dependencies; used by pns_dot and the top level of the block.
`timescale 1ns / 1ps
package pns_pkg;

	// Width of a corner dot product and of every blended value (16 fraction bits).
	localparam int VAL_W   = 20;
	localparam int NOISE_W = 17;

	localparam logic signed [VAL_W-1:0] NOISE_MIN = -VAL_W'(65536);
	localparam logic signed [VAL_W-1:0] NOISE_MAX = VAL_W'(65535);

	localparam logic KIND_WRITE  = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_LERP = 3'b100
	} state_t;

	// Tag that travels with a gradient read through the dot product pipeline.
	typedef struct packed {
		logic       valid;
		logic [2:0] corner;
	} corner_tag_t;

endpackage

[rtl/pns_ram.sv]
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
module pns_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

[rtl/pns_fade.sv]
// Quintic fade curve for one axis, evaluated by Horner's rule, one product a cycle while step is high.
// No package dependencies.
`timescale 1ns / 1ps
module pns_fade #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 load,
	input  logic                 step,
	input  logic                 step_add,
	input  logic [FRAC_BITS-1:0] t_in,
	output logic [FRAC_BITS:0]   s
);

	localparam int FD_W = FRAC_BITS + 6;
	localparam int P_W  = FD_W + FRAC_BITS + 2;
	localparam logic signed [FD_W-1:0] ONE     = FD_W'(1) << FRAC_BITS;
	localparam logic signed [FD_W-1:0] FIFTEEN = FD_W'(15) << FRAC_BITS;
	localparam logic signed [FD_W-1:0] TEN     = FD_W'(10) << FRAC_BITS;

	logic [FRAC_BITS-1:0]   t_q;
	logic signed [FD_W-1:0] acc_q;
	logic signed [FD_W-1:0] te;
	logic signed [P_W-1:0]  prod;
	logic signed [FD_W-1:0] next;

	assign te   = FD_W'($signed({1'b0, t_in}));
	assign prod = P_W'(acc_q) * P_W'($signed({1'b0, t_q}));
	assign next = FD_W'(prod >>> FRAC_BITS) + (step_add ? TEN : '0);

	always_ff @(posedge clk) begin
		if (load) begin
			t_q   <= t_in;
			acc_q <= (te <<< 2) + (te <<< 1) - FIFTEEN;
		end else if (step) begin
			acc_q <= next;
		end
	end

	always_comb begin
		if (acc_q < 0) begin
			s = '0;
		end else if (acc_q > ONE) begin
			s = (FRAC_BITS+1)'(ONE);
		end else begin
			s = (FRAC_BITS+1)'(acc_q);
		end
	end

endmodule

[rtl/pns_dot.sv]
// Corner dot product: offset times gradient word read from the gradient memory.
// Depends on pns_pkg for the value width and the corner tag.
`timescale 1ns / 1ps
module pns_dot #(
	parameter int FRAC_BITS = 16,
	parameter int GRAD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pns_pkg::corner_tag_t          tag_s1,
	input  logic [3*GRAD_BITS-1:0]        grad_word,
	input  logic [FRAC_BITS-1:0]          fr_x,
	input  logic [FRAC_BITS-1:0]          fr_y,
	input  logic [FRAC_BITS-1:0]          fr_z,
	output pns_pkg::corner_tag_t          tag_s2,
	output logic signed [pns_pkg::VAL_W-1:0] v
);
	import pns_pkg::*;

	localparam int D_W   = FRAC_BITS + 2;
	localparam int M_W   = D_W + GRAD_BITS;
	localparam int ACC_W = M_W + 2;
	localparam int SH    = FRAC_BITS + GRAD_BITS - 17;
	localparam int SHR   = (SH > 0) ? SH : 0;
	localparam int SHL   = (SH < 0) ? -SH : 0;
	localparam logic signed [D_W-1:0] ONE = D_W'(1) << FRAC_BITS;

	logic signed [D_W-1:0]       dx, dy, dz;
	logic signed [GRAD_BITS-1:0] gx, gy, gz;
	logic signed [M_W-1:0]       px_s2, py_s2, pz_s2;
	logic signed [ACC_W-1:0]     acc;

	assign gx = grad_word[GRAD_BITS-1:0];
	assign gy = grad_word[2*GRAD_BITS-1:GRAD_BITS];
	assign gz = grad_word[3*GRAD_BITS-1:2*GRAD_BITS];

	// The upper corner on an axis sees the offset less one cell.
	assign dx = D_W'($signed({1'b0, fr_x})) - (tag_s1.corner[0] ? ONE : '0);
	assign dy = D_W'($signed({1'b0, fr_y})) - (tag_s1.corner[1] ? ONE : '0);
	assign dz = D_W'($signed({1'b0, fr_z})) - (tag_s1.corner[2] ? ONE : '0);

	always_ff @(posedge clk) begin
		px_s2 <= M_W'(dx) * M_W'(gx);
		py_s2 <= M_W'(dy) * M_W'(gy);
		pz_s2 <= M_W'(dz) * M_W'(gz);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag_s1;
		end
	end

	assign acc = ACC_W'(px_s2) + ACC_W'(py_s2) + ACC_W'(pz_s2);
	assign v   = VAL_W'((acc >>> SHR) <<< SHL);

endmodule

[rtl/perlin_noise_3d_sampler_core.sv]
// Top level of the 3D gradient noise sampler: control, gradient memory and blending.
// Depends on pns_pkg, pns_ram, pns_fade and pns_dot.
`timescale 1ns / 1ps
// Usage
// One input channel (in_valid / in_stall) carries both kinds of request. A write
// request (kind 0) stores one node's gradient in the gradient memory in the cycle
// it is accepted and gives no result. A sample request (kind 1) gives one result
// on the output channel (out_valid / out_stall, noise_value).
// A sample occupies the block once it is accepted: first the eight corner gradients
// are read, one per cycle, from the single-port gradient memory and passed through
// the dot product pipeline, then the seven lerps run on one shared multiplier; the
// result is in the output register in the cycle after the last lerp, when the next
// request can already be accepted. in_stall is high while a sample is in progress
// and stays low for a write.
// A result waits in the output register while out_stall is high; the last lerp of
// the following sample holds until that register is free.
// Reset clears the control state only. Gradient memory contents are undefined
// until written, so each node must be written before a sample reads it.
module perlin_noise_3d_sampler_core #(
	parameter int NODES_PER_AXIS = 16,
	parameter int FRAC_BITS      = 16,
	parameter int GRAD_BITS      = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                kind,
	input  logic [11:0]                         node_index,
	input  logic signed [GRAD_BITS-1:0]         grad_x,
	input  logic signed [GRAD_BITS-1:0]         grad_y,
	input  logic signed [GRAD_BITS-1:0]         grad_z,
	input  logic [19:0]                         pos_x,
	input  logic [19:0]                         pos_y,
	input  logic [19:0]                         pos_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [pns_pkg::NOISE_W-1:0]  noise_value
);
	import pns_pkg::*;

	localparam int DEPTH = NODES_PER_AXIS * NODES_PER_AXIS * NODES_PER_AXIS;
	localparam int A_W   = $clog2(DEPTH);
	localparam int C_W   = $clog2(NODES_PER_AXIS);
	localparam int S_W   = FRAC_BITS + 1;
	localparam int LP_W  = VAL_W + 1 + S_W + 1;
	localparam logic [31:0] POS_LIMIT = 32'(((NODES_PER_AXIS - 1) << FRAC_BITS) - 1);
	localparam logic [3:0]  LAST_CYC  = 4'd9;
	localparam logic [2:0]  LAST_STEP = 3'd6;

	function automatic logic [31:0] sat_pos(input logic [19:0] p);
		logic [31:0] w;
		w = 32'(p);
		return (w > POS_LIMIT) ? POS_LIMIT : w;
	endfunction

	state_t state_q;
	logic [3:0] cyc_q;
	logic [2:0] step_q;
	logic       ph_q;
	logic [3:0] len_q;

	logic [31:0] px, py, pz;
	logic [FRAC_BITS-1:0] fr_x_q, fr_y_q, fr_z_q;
	logic [C_W-1:0] cx_q, cy_q, cz_q;

	logic accept, do_write, do_sample, issue, out_free, out_load;
	logic [2:0] corner;
	logic [31:0] node;
	logic [A_W-1:0] ram_addr;
	logic [3*GRAD_BITS-1:0] ram_rdata;
	corner_tag_t tag_s1, tag_s2;
	logic signed [VAL_W-1:0] dot_v;

	logic [S_W-1:0] s_x, s_y, s_z, s_sel;
	logic fade_step, fade_add;

	logic signed [VAL_W-1:0] q_q [8];
	logic signed [LP_W-1:0]  prod_q;
	logic signed [VAL_W:0]   diff;
	logic signed [VAL_W-1:0] res;
	logic [2:0] wr_idx;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign do_write  = accept && (kind == KIND_WRITE) && (32'(node_index) < 32'(DEPTH));
	assign do_sample = accept && (kind == KIND_SAMPLE);
	assign out_free  = !out_valid || !out_stall;
	assign out_load  = (state_q == ST_LERP) && ph_q && (step_q == LAST_STEP) && out_free;

	assign px = sat_pos(pos_x);
	assign py = sat_pos(pos_y);
	assign pz = sat_pos(pos_z);

	assign issue  = (state_q == ST_RUN) && (cyc_q < 4'd8);
	assign corner = cyc_q[2:0];
	assign node   = ((32'(cz_q) + 32'(corner[2])) * 32'(NODES_PER_AXIS)
	                + 32'(cy_q) + 32'(corner[1])) * 32'(NODES_PER_AXIS)
	                + 32'(cx_q) + 32'(corner[0]);
	assign ram_addr = do_write ? A_W'(node_index) : A_W'(node);

	pns_ram #(
		.WIDTH(3 * GRAD_BITS),
		.DEPTH(DEPTH)
	) u_grad_ram (
		.clk  (clk),
		.en   (do_write || issue),
		.we   (do_write),
		.addr (ram_addr),
		.wdata({grad_z, grad_y, grad_x}),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.valid  <= issue;
			tag_s1.corner <= corner;
		end
	end

	pns_dot #(
		.FRAC_BITS(FRAC_BITS),
		.GRAD_BITS(GRAD_BITS)
	) u_dot (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag_s1   (tag_s1),
		.grad_word(ram_rdata),
		.fr_x     (fr_x_q),
		.fr_y     (fr_y_q),
		.fr_z     (fr_z_q),
		.tag_s2   (tag_s2),
		.v        (dot_v)
	);

	assign fade_step = (state_q == ST_RUN) && (cyc_q < 4'd4);
	assign fade_add  = (cyc_q == 4'd0);

	pns_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
		.clk(clk), .load(do_sample), .step(fade_step), .step_add(fade_add),
		.t_in(px[FRAC_BITS-1:0]), .s(s_x)
	);
	pns_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
		.clk(clk), .load(do_sample), .step(fade_step), .step_add(fade_add),
		.t_in(py[FRAC_BITS-1:0]), .s(s_y)
	);
	pns_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_z (
		.clk(clk), .load(do_sample), .step(fade_step), .step_add(fade_add),
		.t_in(pz[FRAC_BITS-1:0]), .s(s_z)
	);

	always_ff @(posedge clk) begin
		if (do_sample) begin
			fr_x_q <= px[FRAC_BITS-1:0];
			fr_y_q <= py[FRAC_BITS-1:0];
			fr_z_q <= pz[FRAC_BITS-1:0];
			cx_q   <= px[FRAC_BITS +: C_W];
			cy_q   <= py[FRAC_BITS +: C_W];
			cz_q   <= pz[FRAC_BITS +: C_W];
		end
	end

	// The lerps work on a queue: the two values at its head are blended and the
	// result joins its tail, which yields the x, then y, then z blending order.
	always_comb begin
		if (step_q < 3'd4) begin
			s_sel = s_x;
		end else if (step_q < LAST_STEP) begin
			s_sel = s_y;
		end else begin
			s_sel = s_z;
		end
	end

	assign diff   = (VAL_W+1)'(q_q[1]) - (VAL_W+1)'(q_q[0]);
	assign res    = q_q[0] + VAL_W'(prod_q >>> FRAC_BITS);
	assign wr_idx = 3'(len_q - 4'd2);

	always_ff @(posedge clk) begin
		if (tag_s2.valid) begin
			q_q[tag_s2.corner] <= dot_v;
		end
		if (state_q == ST_LERP) begin
			if (!ph_q) begin
				prod_q <= LP_W'(diff) * LP_W'($signed({1'b0, s_sel}));
			end else if (step_q != LAST_STEP) begin
				for (int i = 0; i < 6; i++) begin
					q_q[i] <= q_q[i+2];
				end
				q_q[wr_idx] <= res;
			end
		end
		if (out_load) begin
			if (res < NOISE_MIN) begin
				noise_value <= NOISE_W'(NOISE_MIN);
			end else if (res > NOISE_MAX) begin
				noise_value <= NOISE_W'(NOISE_MAX);
			end else begin
				noise_value <= NOISE_W'(res);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cyc_q     <= '0;
			step_q    <= '0;
			ph_q      <= 1'b0;
			len_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall && !out_load) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (do_sample) begin
						state_q <= ST_RUN;
						cyc_q   <= '0;
					end
				end
				ST_RUN: begin
					cyc_q <= cyc_q + 4'd1;
					if (cyc_q == LAST_CYC) begin
						state_q <= ST_LERP;
						step_q  <= '0;
						ph_q    <= 1'b0;
						len_q   <= 4'd8;
					end
				end
				ST_LERP: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else if (step_q != LAST_STEP) begin
						ph_q   <= 1'b0;
						step_q <= step_q + 3'd1;
						len_q  <= len_q - 4'd1;
					end else if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
